// File: src/itdt_pkg.sv
package itdt_pkg;

	localparam int ValueW     = 32;
	localparam int CapW       = 8;
	localparam int CharW      = 8;
	localparam int PosW       = 4;
	localparam int DigitW     = 4;
	localparam int NumCells   = 10;
	localparam int StepBits   = 4;
	localparam int ConvCycles = ValueW / StepBits;
	localparam int CntW       = $clog2(ConvCycles);
	localparam int InDataW    = 40;
	localparam int OutDataW   = 16;

	localparam logic [CharW-1:0] CharZero  = 8'd48;
	localparam logic [CharW-1:0] CharMinus = 8'd45;
	localparam logic [CharW-1:0] CharNul   = 8'd0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIZE,
		ST_EMIT
	} itdt_state_t;

	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctrl_t;

endpackage

// File: src/integer_to_decimal_text.sv
// Converts a signed 32-bit value to decimal ASCII for a buffer of the given
// capacity (terminator included) and sends one byte per beat in buffer order:
// an optional '-', the digits most significant first, then a zero terminator
// marked by tlast. Short buffers lose leading digits; capacity 0, or a zero
// value with capacity 1, produces no beats. One item is handled at a time.
// After acceptance a row of ten BCD digit cells converts the magnitude 4 bits
// per cycle, a sizing state then fixes the length, then the 1 to 12 bytes
// leave at one per cycle when the output is not stalled.
module integer_to_decimal_text
	import itdt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [InDataW-1:0]  s_axis_tdata,   // [31:0] value, [39:32] capacity
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OutDataW-1:0] m_axis_tdata,   // [7:0] char_code, [11:8] position, zeros above
	output logic                m_axis_tlast
);

	itdt_state_t state_q, state_next;

	logic [ValueW-1:0] mag_q;
	logic [CapW-1:0]   cap_q;
	logic              neg_q;
	logic [CntW-1:0]   cnt_q;
	logic [PosW-1:0]   len_q;
	logic              sign_q;
	logic [PosW-1:0]   pos_q;

	logic              out_valid_q;
	logic [CharW-1:0]  out_char_q;
	logic [PosW-1:0]   out_pos_q;
	logic              out_last_q;

	logic signed [ValueW-1:0] in_value;
	logic [CapW-1:0]          in_cap;
	logic                     in_accept;
	logic                     in_drop;
	logic                     out_take;
	logic                     out_load;
	cell_ctrl_t               cell_ctrl;

	logic [StepBits-1:0] carry [NumCells];
	logic [DigitW-1:0]   digit [NumCells];

	logic [PosW-1:0]  num_digits;
	logic [CapW-1:0]  cap_m1;
	logic [PosW-1:0]  kept;
	logic             sign_fits;
	logic [PosW-1:0]  digit_idx;
	logic [DigitW-1:0] digit_sel;
	logic [CharW-1:0] char_next;
	logic             last_next;

	assign in_value  = s_axis_tdata[ValueW-1:0];
	assign in_cap    = s_axis_tdata[ValueW+CapW-1:ValueW];
	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign in_drop   = (in_cap == '0) || ((in_value == '0) && (in_cap == 8'd1));
	assign out_take  = out_valid_q && m_axis_tready;

	assign carry[0] = mag_q[ValueW-1:ValueW-StepBits];

	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		if (i < NumCells - 1) begin : g_mid
			itdt_cell u_cell (
				.clk   (clk),
				.ctrl  (cell_ctrl),
				.cin   (carry[i]),
				.cout  (carry[i+1]),
				.digit (digit[i])
			);
		end else begin : g_top
			itdt_cell u_cell (
				.clk   (clk),
				.ctrl  (cell_ctrl),
				.cin   (carry[i]),
				.cout  (),
				.digit (digit[i])
			);
		end
	end

	// Count of significant digits; a zero value still has one digit.
	always_comb begin
		num_digits = 4'd1;
		for (int i = 0; i < NumCells; i++) begin
			if (digit[i] != '0) begin
				num_digits = PosW'(i + 1);
			end
		end
	end

	assign cap_m1    = cap_q - 8'd1;
	assign kept      = ({4'b0, num_digits} <= cap_m1) ? num_digits : cap_m1[PosW-1:0];
	assign sign_fits = neg_q && ({4'b0, kept} < cap_m1);

	assign digit_idx = len_q - 4'd1 - pos_q;

	always_comb begin
		digit_sel = '0;
		for (int i = 0; i < NumCells; i++) begin
			if (digit_idx == PosW'(i)) begin
				digit_sel = digit[i];
			end
		end
	end

	always_comb begin
		last_next = (pos_q == len_q);
		if (last_next) begin
			char_next = CharNul;
		end else if (sign_q && (pos_q == '0)) begin
			char_next = CharMinus;
		end else begin
			char_next = CharZero + {4'b0, digit_sel};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next      = state_q;
		s_axis_tready   = 1'b0;
		cell_ctrl.clear = 1'b0;
		cell_ctrl.shift = 1'b0;
		out_load        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready   = 1'b1;
				cell_ctrl.clear = s_axis_tvalid;
				if (s_axis_tvalid && !in_drop) begin
					state_next = ST_CONV;
				end
			end
			ST_CONV: begin
				cell_ctrl.shift = 1'b1;
				if (cnt_q == CntW'(ConvCycles - 1)) begin
					state_next = ST_SIZE;
				end
			end
			ST_SIZE: begin
				state_next = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					if (last_next) begin
						state_next = ST_IDLE;
					end
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				cnt_q <= '0;
			end else if (cell_ctrl.shift) begin
				cnt_q <= cnt_q + CntW'(1);
			end
			if (state_q == ST_SIZE) begin
				pos_q <= '0;
			end else if (out_load) begin
				pos_q <= pos_q + PosW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			neg_q <= in_value[ValueW-1];
			// The most negative value negates to itself, which read unsigned is
			// its true magnitude.
			mag_q <= in_value[ValueW-1] ? (~in_value + 32'd1) : in_value;
			cap_q <= in_cap;
		end else if (cell_ctrl.shift) begin
			mag_q <= {mag_q[ValueW-StepBits-1:0], {StepBits{1'b0}}};
		end
		if (state_q == ST_SIZE) begin
			len_q  <= kept + {3'b0, sign_fits};
			sign_q <= sign_fits;
		end
		if (out_load) begin
			out_char_q <= char_next;
			out_pos_q  <= pos_q;
			out_last_q <= last_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_pos_q, out_char_q};
	assign m_axis_tlast  = out_last_q;

endmodule

// File: src/itdt_cell.sv
module itdt_cell
	import itdt_pkg::*;
(
	input  logic                clk,
	input  cell_ctrl_t          ctrl,
	input  logic [StepBits-1:0] cin,
	output logic [StepBits-1:0] cout,
	output logic [DigitW-1:0]   digit
);

	logic [DigitW-1:0] digit_q;
	logic [DigitW-1:0] digit_next;

	// Each step adds three to a digit of five or more, then shifts in one bit
	// from the neighbor below; the bit shifted out feeds the neighbor above.
	always_comb begin
		logic [DigitW-1:0] d;
		logic [DigitW-1:0] adj;
		d    = digit_q;
		cout = '0;
		for (int s = StepBits - 1; s >= 0; s--) begin
			adj     = (d >= 4'd5) ? (d + 4'd3) : d;
			cout[s] = adj[DigitW-1];
			d       = {adj[DigitW-2:0], cin[s]};
		end
		digit_next = d;
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.shift) begin
			digit_q <= digit_next;
		end
	end

	assign digit = digit_q;

endmodule

// File: tb/sv/integer_to_decimal_text_tb.sv
`timescale 1ns / 100ps

module integer_to_decimal_text_tb;
	import itdt_pkg::*;

	localparam int ClkPeriod   = 12;
	localparam int ResetCycles = 9;
	localparam int RandomItems = 430;
	localparam int IdleLimit   = 4000;
	localparam int DrainCycles = 40;
	localparam int HoldCycles  = 400;

	typedef struct packed {
		logic [CharW-1:0] code;
		logic [PosW-1:0]  pos;
		logic             last;
	} text_byte_t;

	class decimal_text_board;
		text_byte_t pending_bytes[$];
		int         failures;
		int         reported;

		function new();
			failures = 0;
			reported = 0;
		endfunction

		// Works out the bytes that converting one value into a buffer of the given
		// capacity writes, in buffer order.
		function void note_conversion(logic [ValueW-1:0] value, logic [CapW-1:0] capacity);
			logic [ValueW-1:0] mag;
			logic [CapW-1:0]   room;
			logic [CharW-1:0]  rev[12];
			text_byte_t        b;
			int                n;
			if (capacity == '0)
				return;
			if (value == '0) begin
				if (capacity > 1) begin
					b.code = CharZero; b.pos = 4'd0; b.last = 1'b0;
					pending_bytes.push_back(b);
					b.code = CharNul; b.pos = 4'd1; b.last = 1'b1;
					pending_bytes.push_back(b);
				end
				return;
			end
			// Two's complement negation leaves 0x80000000 at its true magnitude.
			mag  = value[ValueW-1] ? (32'd0 - value) : value;
			room = capacity - 8'd1;
			n    = 0;
			while (mag != 0 && n < int'(room) && n < NumCells) begin
				rev[n] = CharZero + 8'(mag % 32'd10);
				mag    = mag / 32'd10;
				n++;
			end
			if (value[ValueW-1] && n < int'(room)) begin
				rev[n] = CharMinus;
				n++;
			end
			for (int p = 0; p < n; p++) begin
				b.code = rev[n-1-p];
				b.pos  = PosW'(p);
				b.last = 1'b0;
				pending_bytes.push_back(b);
			end
			b.code = CharNul;
			b.pos  = PosW'(n);
			b.last = 1'b1;
			pending_bytes.push_back(b);
		endfunction

		function void check_byte(logic [OutDataW-1:0] data, logic tlast);
			text_byte_t want;
			if (pending_bytes.size() == 0) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display("ERROR: unexpected byte code=%0d pos=%0d last=%0b",
						data[7:0], data[11:8], tlast);
				end
				return;
			end
			want = pending_bytes.pop_front();
			if (data[7:0] !== want.code || data[11:8] !== want.pos || tlast !== want.last
					|| data[OutDataW-1:12] !== '0) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display({"ERROR: expected code=%0d pos=%0d last=%0b, ",
						"got code=%0d pos=%0d last=%0b pad=%h"},
						want.code, want.pos, want.last, data[7:0], data[11:8], tlast,
						data[OutDataW-1:12]);
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [InDataW-1:0]  s_axis_tdata;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OutDataW-1:0] m_axis_tdata;
	logic                m_axis_tlast;

	decimal_text_board board;
	int                bytes_seen;
	int                idle_cycles;
	bit                burst_mode;

	integer_to_decimal_text uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #(ClkPeriod / 2) clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 2);
		else if (r < 95)
			return $urandom_range(3, 8);
		else
			return $urandom_range(20, 60);
	endfunction

	task automatic send_item(input logic [ValueW-1:0] value, input logic [CapW-1:0] capacity);
		int gap;
		gap = burst_mode ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {capacity, value};
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
	endtask

	function automatic logic [ValueW-1:0] random_value();
		int unsigned powers[10];
		logic [ValueW-1:0] v;
		int r;
		powers = '{1, 10, 100, 1000, 10000, 100000, 1000000, 10000000,
			100000000, 1000000000};
		r = $urandom_range(0, 99);
		if (r < 40) begin
			v = $urandom;
		end else if (r < 65) begin
			v = $urandom_range(0, 999);
			if ($urandom_range(0, 1)) v = -v;
		end else if (r < 80) begin
			// Values around a power of ten change the digit count.
			v = powers[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
			if ($urandom_range(0, 1)) v = -v;
		end else if (r < 90) begin
			case ($urandom_range(0, 5))
				0: v = 32'h0000_0000;
				1: v = 32'h0000_0001;
				2: v = 32'hFFFF_FFFF;
				3: v = 32'h7FFF_FFFF;
				4: v = 32'h8000_0000;
				default: v = 32'h8000_0001;
			endcase
		end else begin
			v = $urandom >> $urandom_range(0, 31);
			if ($urandom_range(0, 1)) v = -v;
		end
		return v;
	endfunction

	function automatic logic [CapW-1:0] random_capacity();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return CapW'($urandom_range(0, 13));
		else if (r < 85)
			return CapW'($urandom_range(1, 12));
		else
			return CapW'($urandom_range(0, 255));
	endfunction

	// Scoreboard updates for both sides happen in one process so their order is fixed.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				board.note_conversion(s_axis_tdata[31:0], s_axis_tdata[39:32]);
			if (m_axis_tvalid && m_axis_tready) begin
				board.check_byte(m_axis_tdata, m_axis_tlast);
				bytes_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off while the sender keeps offering.
	initial begin
		bit held;
		int on_len;
		int off_len;
		int r;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && bytes_seen >= 80) begin
				m_axis_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				held = 1'b1;
			end
			on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 8);
			m_axis_tready <= 1'b1;
			repeat (on_len) @(posedge clk);
			r = $urandom_range(0, 99);
			if (r < 70)
				off_len = 0;
			else if (r < 90)
				off_len = $urandom_range(1, 3);
			else if (r < 98)
				off_len = $urandom_range(4, 12);
			else
				off_len = $urandom_range(20, 60);
			if (off_len > 0) begin
				m_axis_tready <= 1'b0;
				repeat (off_len) @(posedge clk);
			end
		end
	end

	initial begin
		logic [ValueW-1:0] dir_value[23];
		logic [CapW-1:0]   dir_cap[23];
		board         = new();
		bytes_seen    = 0;
		idle_cycles   = 0;
		burst_mode    = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;

		// Zero with every small capacity, the most negative value with and without
		// room for its sign, the largest value truncated, and sign dropping.
		dir_value = '{32'd0, 32'd0, 32'd0, 32'd0,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			-32'sd1, -32'sd1, 32'd1, 32'd1,
			-32'sd123, -32'sd123, 32'd1000000000, -32'sd999999999,
			32'd5, 32'd42};
		dir_cap = '{8'd0, 8'd1, 8'd2, 8'd255,
			8'd255, 8'd12, 8'd11, 8'd2, 8'd1, 8'd0,
			8'd12, 8'd11, 8'd4,
			8'd2, 8'd3, 8'd1, 8'd2,
			8'd4, 8'd5, 8'd12, 8'd11,
			8'd200, 8'd13};

		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_value[i])
			send_item(dir_value[i], dir_cap[i]);

		for (int i = 0; i < RandomItems; i++) begin
			if (i % 40 == 0)
				burst_mode = ($urandom_range(0, 3) == 0);
			send_item(random_value(), random_capacity());
		end
		s_axis_tvalid <= 1'b0;

		while (board.pending_bytes.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (board.pending_bytes.size() != 0) begin
			board.failures++;
			$display("ERROR: %0d expected bytes never arrived", board.pending_bytes.size());
		end
		if (board.failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: files.f
src/itdt_pkg.sv
src/itdt_cell.sv
src/integer_to_decimal_text.sv
tb/sv/integer_to_decimal_text_tb.sv
